FILE: rtl/core/sorted_table_linear_interpolation_top_defines.svh
// Assertion macros for the sorted table interpolation block.
// Used by the port checker; depends on nothing else.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATION_TOP_DEFINES_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define STI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held.
`define STI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sti_pkg.sv
// Shared types and constants of the sorted table interpolation block.
// No dependencies.
`timescale 1ns / 1ps

package sti_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_VALID = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] lift;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/core/sti_ram.sv
// Table memory holding (angle, coefficient) pairs, one write and one read port.
// Depends on sti_pkg.
`timescale 1ns / 1ps

module sti_ram #(
    parameter int DEPTH = sti_pkg::TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sti_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output sti_pkg::entry_t rdata
);

    sti_pkg::entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sti_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sti_pkg.
`timescale 1ns / 1ps

module sti_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sti_pkg::div_req_t req,
    output sti_pkg::div_rsp_t rsp
);

    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] shifted;
    logic [16:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                den_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (shifted >= {1'b0, den_reg}) begin
                    rem_reg <= diff[15:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= shifted[15:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/sorted_table_linear_interpolation_top.sv
// Sorted (angle, coefficient) table with linear interpolation, top level.
// Depends on sti_pkg, sti_ram and sti_div.
//
// Input words carry mode, angle and coefficient on a valid/ready channel;
// every input word yields exactly one result word (status, lift_value).
// A load inserts a pair in angle order behind equal keys, a clear empties
// the table, a query returns the matching or interpolated coefficient.
// One word is in work at a time; s_ready is high only while idle.
// A load walks down from the top of the table, moving one entry per cycle.
// A query scans up from the bottom, one entry per cycle, then passes
// through a multiply step, a divider start step and a serial divide.
// Clears and full or empty cases go straight to the finish state.
// The table memory's single read port sets the scan rate, the divider
// the interpolation time. Reset empties the table at once; memory
// contents need no clearing. The result sits in an output register;
// while the receiver stalls the finished result holds and the block
// waits before storing the next one.
`timescale 1ns / 1ps

module sorted_table_linear_interpolation_top #(
    parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [15:0] s_angle,
    input  logic signed [15:0] s_coefficient,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [15:0] m_lift_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LCMP, S_LINS, S_QCMP, S_MUL, S_DIVGO, S_DIVWAIT, S_FINISH
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic signed [15:0] key_reg;
    logic signed [15:0] coef_reg;
    logic signed [15:0] prev_angle_reg;
    logic signed [15:0] prev_lift_reg;
    logic [15:0]        num_reg;
    logic [15:0]        den_reg;
    logic [15:0]        dy_mag_reg;
    logic               dy_neg_reg;
    logic [31:0]        prod_reg;
    logic [2:0]         res_status_reg;
    logic signed [15:0] res_lift_reg;
    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic signed [15:0] m_lift_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    sti_pkg::entry_t    ram_wdata;
    sti_pkg::entry_t    ram_rdata;
    sti_pkg::entry_t    new_entry;
    sti_pkg::div_req_t  div_req;
    sti_pkg::div_rsp_t  div_rsp;

    logic [16:0]        dy_wide;
    logic [16:0]        dy_abs;
    logic [15:0]        q_signed;

    assign new_entry.angle = key_reg;
    assign new_entry.lift  = coef_reg;

    sti_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_req.start    = (state_reg == S_DIVGO);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = den_reg;

    sti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = new_entry;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_mode == sti_pkg::MODE_LOAD) begin
                    ram_raddr = AW'(count_reg - CW'(1));
                end
            end
            S_LCMP: begin
                ram_we = 1'b1;
                if (ram_rdata.angle > key_reg) begin
                    ram_wdata = ram_rdata;
                end
                ram_raddr = AW'(idx_reg - CW'(2));
            end
            S_LINS: begin
                ram_we = 1'b1;
            end
            S_QCMP: begin
                ram_raddr = AW'(idx_reg + CW'(1));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign dy_wide  = {ram_rdata.lift[15], ram_rdata.lift}
                      - {prev_lift_reg[15], prev_lift_reg};
    assign dy_abs   = dy_wide[16] ? (17'd0 - dy_wide) : dy_wide;
    assign q_signed = dy_neg_reg ? (16'd0 - div_rsp.quotient[15:0])
                                 : div_rsp.quotient[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        key_reg      <= s_angle;
                        coef_reg     <= s_coefficient;
                        res_lift_reg <= '0;
                        case (s_mode)
                            sti_pkg::MODE_LOAD: begin
                                idx_reg <= count_reg;
                                if (count_reg == CW'(TABLE_DEPTH)) begin
                                    res_status_reg <= sti_pkg::ST_FULL;
                                    state_reg      <= S_FINISH;
                                end else if (count_reg == '0) begin
                                    res_status_reg <= sti_pkg::ST_DONE;
                                    state_reg      <= S_LINS;
                                end else begin
                                    res_status_reg <= sti_pkg::ST_DONE;
                                    state_reg      <= S_LCMP;
                                end
                            end
                            sti_pkg::MODE_QUERY: begin
                                idx_reg <= '0;
                                if (count_reg == '0) begin
                                    res_status_reg <= sti_pkg::ST_EMPTY;
                                    state_reg      <= S_FINISH;
                                end else begin
                                    res_status_reg <= sti_pkg::ST_DONE;
                                    state_reg      <= S_QCMP;
                                end
                            end
                            sti_pkg::MODE_CLEAR: begin
                                count_reg      <= '0;
                                res_status_reg <= sti_pkg::ST_DONE;
                                state_reg      <= S_FINISH;
                            end
                            default: begin
                                res_status_reg <= sti_pkg::ST_DONE;
                                state_reg      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_LCMP: begin
                    if (ram_rdata.angle > key_reg) begin
                        idx_reg <= idx_reg - CW'(1);
                        if (idx_reg == CW'(1)) begin
                            state_reg <= S_LINS;
                        end
                    end else begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_FINISH;
                    end
                end
                S_LINS: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_FINISH;
                end
                S_QCMP: begin
                    if (ram_rdata.angle == key_reg) begin
                        res_status_reg <= sti_pkg::ST_VALID;
                        res_lift_reg   <= ram_rdata.lift;
                        state_reg      <= S_FINISH;
                    end else if (ram_rdata.angle > key_reg) begin
                        if (idx_reg == '0) begin
                            res_status_reg <= sti_pkg::ST_RANGE;
                            state_reg      <= S_FINISH;
                        end else begin
                            num_reg    <= 16'(key_reg - prev_angle_reg);
                            den_reg    <= 16'(ram_rdata.angle - prev_angle_reg);
                            dy_neg_reg <= dy_wide[16];
                            dy_mag_reg <= dy_abs[15:0];
                            state_reg  <= S_MUL;
                        end
                    end else begin
                        prev_angle_reg <= ram_rdata.angle;
                        prev_lift_reg  <= ram_rdata.lift;
                        idx_reg        <= idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == count_reg) begin
                            res_status_reg <= sti_pkg::ST_RANGE;
                            state_reg      <= S_FINISH;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= num_reg * dy_mag_reg;
                    state_reg <= S_DIVGO;
                end
                S_DIVGO: begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_rsp.done) begin
                        res_status_reg <= sti_pkg::ST_VALID;
                        res_lift_reg   <= prev_lift_reg + $signed(q_signed);
                        state_reg      <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_lift_reg   <= res_lift_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_lift_value = m_lift_reg;

endmodule

FILE: rtl/core/sti_checker.sv
// Port-level checker for the sorted table interpolation block, with its bind.
// Depends on sti_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_table_linear_interpolation_top_defines.svh"

module sti_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [2:0]         m_status,
    input logic signed [15:0] m_lift_value
);

    `STI_ASSERT_NOW(a_lift_zero, m_valid && (m_status != sti_pkg::ST_VALID), m_lift_value == 16'sd0, "Lift value nonzero without a valid status.")
    `STI_ASSERT_NOW(a_status_code, m_valid, m_status <= sti_pkg::ST_EMPTY, "Status code out of range.")
    `STI_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "Input taken again before the word in work finished.")
    `STI_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_lift_value), "Stalled result word changed.")

endmodule

bind sorted_table_linear_interpolation_top sti_checker u_sti_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_lift_value (m_lift_value)
);
